/* rtl/lscp_pkg.sv */
package lscp_pkg;

    // fixed field widths of the request and result channels
    localparam int SENSOR_W = 3;
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 10;
    localparam int POS_W    = 13;

    // running sums and quotient width of the shared divider
    localparam int WSUM_W   = 26;
    localparam int LSUM_W   = 13;
    localparam int QUOT_W   = 16;

    localparam logic CMD_CALIB = 1'b0;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 10'd1000;

    typedef struct packed {
        logic                command;
        logic [SENSOR_W-1:0] sensor_index;
        logic [SAMPLE_W-1:0] sample;
        logic                scan_last;
    } item_t;

    typedef struct packed {
        logic [SENSOR_W-1:0] sensor_number;
        logic [SAMPLE_W-1:0] calib_max;
        logic [SAMPLE_W-1:0] calib_min;
        logic [LEVEL_W-1:0]  level;
        logic                uncalibrated;
        logic [POS_W-1:0]    position;
        logic                position_valid;
    } result_t;

endpackage

/* rtl/lscp_item_if.sv */
interface lscp_item_if;
    import lscp_pkg::*;

    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/lscp_result_if.sv */
interface lscp_result_if;
    import lscp_pkg::*;

    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/lscp_mul.sv */
// shift-add multiplier, one bit of b per cycle; done pulses with product valid
module lscp_mul #(
    parameter int A_W = 13,
    parameter int B_W = 10,
    parameter int P_W = 26
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [A_W-1:0] a,
    input  logic [B_W-1:0] b,
    output logic           done,
    output logic [P_W-1:0] prod
);
    localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [P_W-1:0]   acc_reg, acc_next;
    logic [P_W-1:0]   a_reg, a_next;
    logic [B_W-1:0]   b_reg, b_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            a_next    = P_W'(a);
            b_next    = b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[P_W-2:0], 1'b0};
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(B_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

/* rtl/lscp_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
// needs num < den * 2**Q_W; done pulses with quotient valid
module lscp_div #(
    parameter int N_W = 26,
    parameter int D_W = 13,
    parameter int Q_W = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [Q_W-1:0] quot
);
    localparam int CNT_W = $clog2(Q_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W:0]     rem_reg, rem_next;
    logic [Q_W-1:0]   nq_reg, nq_next;
    logic [D_W-1:0]   den_reg, den_next;
    logic [D_W:0]     trial;
    logic             fits;

    assign trial = {rem_reg[D_W-1:0], nq_reg[Q_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        nq_next   = nq_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = (D_W + 1)'(num >> Q_W);
            nq_next   = num[Q_W-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - {1'b0, den_reg}) : trial;
            nq_next  = {nq_reg[Q_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(Q_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = nq_reg;
endmodule

/* rtl/line_sensor_calibrated_position.sv */
// Line sensor position estimator. A calibration request (command 0) widens the
// stored min/max of one sensor in the cycle it is taken and gives no result.
// A measurement request (command 1) gives one result: the sensor's calibration
// range and its level, 1000 minus the reading scaled to 0..1000 over that
// range (0 for an uncalibrated sensor). Levels are summed, plain and weighted
// by index*1000, over a scan; the request marked scan_last also returns
// position = weighted/plain sum and clears both sums. A measurement skips the
// scaling when the level is fixed by clamping (reading outside the range, flat
// range, uncalibrated sensor). The work is done by the bit-serial shift-add
// multiplier (10 steps, used for the *1000 scaling and the weighting) and the
// radix-2 divider (16 steps, used for normalizing and for the position). One
// request is in work at a time; a finished result waits in the output register
// while the next request is taken.
module line_sensor_calibrated_position #(
    parameter int SENSORS     = 8,
    parameter int SAMPLE_BITS = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    lscp_item_if.sink     item,
    lscp_result_if.source result
);
    import lscp_pkg::*;

    localparam int SW     = SAMPLE_BITS;
    localparam int ADDR_W = $clog2(SENSORS);
    localparam int EXT_W  = ADDR_W + SENSOR_W;
    localparam int DEN_W  = (SW > LSUM_W) ? SW : LSUM_W;
    localparam int NUM_W  = (SW + LEVEL_W > WSUM_W) ? SW + LEVEL_W : WSUM_W;
    localparam logic [QUOT_W-1:0] POS_MAX = QUOT_W'((SENSORS - 1) * 1000);

    // sequencer codes
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PREP   = 4'd1;  // classify reading against range
    localparam logic [3:0] ST_MUL1   = 4'd2;  // (reading - min) * 1000
    localparam logic [3:0] ST_DIV1   = 4'd3;  // ... / (max - min)
    localparam logic [3:0] ST_WEIGHT = 4'd4;  // kick level * index*1000
    localparam logic [3:0] ST_MUL2   = 4'd5;
    localparam logic [3:0] ST_DIV2   = 4'd6;  // weighted sum / level sum
    localparam logic [3:0] ST_DONE   = 4'd7;  // hand result to output reg

    logic [3:0] state_reg, state_next;

    // calibration stores
    logic [SW-1:0] min_reg  [SENSORS];
    logic [SW-1:0] max_reg  [SENSORS];
    logic          seen_reg [SENSORS];

    logic [WSUM_W-1:0] wsum_reg, wsum_next;
    logic [LSUM_W-1:0] lsum_reg, lsum_next;

    // request in work
    logic [SENSOR_W-1:0] idx_reg, idx_next;
    logic [SW-1:0]       smp_reg, smp_next;
    logic                last_reg, last_next;
    logic [SW-1:0]       lo_reg, lo_next;
    logic [SW-1:0]       hi_reg, hi_next;
    logic                uncal_reg, uncal_next;
    logic [LEVEL_W-1:0]  lev_reg, lev_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    logic    res_valid_reg, res_valid_next;
    result_t res_reg, res_next;

    // request decode
    logic                item_fire;
    logic [EXT_W-1:0]    idx_ext;
    logic [ADDR_W-1:0]   addr;
    logic                in_range;
    logic [SW-1:0]       smp_in;
    logic                calib_wr;

    // shared units
    logic             mul_start, mul_done;
    logic [DEN_W-1:0] mul_a;
    logic [LEVEL_W-1:0] mul_b;
    logic [NUM_W-1:0] mul_prod;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [QUOT_W-1:0] div_quot;

    // saturating sum update
    logic [WSUM_W:0]   wsum_add;
    logic [LSUM_W:0]   lsum_add;
    logic [WSUM_W-1:0] wsum_sat;
    logic [LSUM_W-1:0] lsum_sat;
    logic [POS_W-1:0]  weight;
    logic              res_load;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_fire  = item.valid && item.ready;
    assign idx_ext    = EXT_W'(item.payload.sensor_index);
    assign addr       = idx_ext[ADDR_W-1:0];
    assign in_range   = (idx_ext < EXT_W'(SENSORS));
    assign smp_in     = SW'(item.payload.sample);
    assign calib_wr   = item_fire && (item.payload.command == CMD_CALIB) && in_range;

    assign weight   = POS_W'(idx_reg) * POS_W'(FULL_SCALE);
    assign wsum_add = {1'b0, wsum_reg} + (WSUM_W + 1)'(mul_prod);
    assign lsum_add = {1'b0, lsum_reg} + (LSUM_W + 1)'(lev_reg);
    assign wsum_sat = wsum_add[WSUM_W] ? '1 : wsum_add[WSUM_W-1:0];
    assign lsum_sat = lsum_add[LSUM_W] ? '1 : lsum_add[LSUM_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        wsum_next  = wsum_reg;
        lsum_next  = lsum_reg;
        idx_next   = idx_reg;
        smp_next   = smp_reg;
        last_next  = last_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        uncal_next = uncal_reg;
        lev_next   = lev_reg;
        pos_next   = pos_reg;
        mul_start  = 1'b0;
        mul_a      = DEN_W'(smp_reg - lo_reg);
        mul_b      = FULL_SCALE;
        div_start  = 1'b0;
        div_num    = mul_prod;
        div_den    = DEN_W'(hi_reg - lo_reg);
        res_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_fire && (item.payload.command != CMD_CALIB))
                begin
                    idx_next   = item.payload.sensor_index;
                    smp_next   = smp_in;
                    last_next  = item.payload.scan_last;
                    // out-of-range index reads as an untouched sensor
                    lo_next    = in_range ? min_reg[addr] : '1;
                    hi_next    = in_range ? max_reg[addr] : '0;
                    uncal_next = !(in_range && seen_reg[addr]);
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_WEIGHT;
                if (uncal_reg)
                begin
                    lev_next = '0;
                end
                else if (hi_reg <= lo_reg)
                begin
                    lev_next = (smp_reg >= lo_reg) ? '0 : FULL_SCALE;
                end
                else if (smp_reg < lo_reg)
                begin
                    lev_next = FULL_SCALE;
                end
                else if (smp_reg >= hi_reg)
                begin
                    lev_next = '0;
                end
                else
                begin
                    // inside the range (min <= reading < max): quotient stays below 1000
                    mul_start  = 1'b1;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    lev_next   = FULL_SCALE - div_quot[LEVEL_W-1:0];
                    state_next = ST_WEIGHT;
                end
            end
            ST_WEIGHT:
            begin
                mul_start  = 1'b1;
                mul_a      = DEN_W'(weight);
                mul_b      = lev_reg;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                div_num = NUM_W'(wsum_sat);
                div_den = DEN_W'(lsum_sat);
                if (mul_done)
                begin
                    pos_next   = '0;
                    state_next = ST_DONE;
                    if (last_reg)
                    begin
                        wsum_next = '0;
                        lsum_next = '0;
                        if (lsum_sat != '0)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV2;
                        end
                    end
                    else
                    begin
                        wsum_next = wsum_sat;
                        lsum_next = lsum_sat;
                    end
                end
            end
            ST_DIV2:
            begin
                if (div_done)
                begin
                    pos_next   = (div_quot > POS_MAX) ? POS_W'(POS_MAX)
                                                      : POS_W'(div_quot);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_next                = res_reg;
        res_valid_next          = res_valid_reg && !result.ready;
        if (res_load)
        begin
            res_valid_next          = 1'b1;
            res_next.sensor_number  = idx_reg;
            res_next.calib_max      = SAMPLE_W'(hi_reg);
            res_next.calib_min      = SAMPLE_W'(lo_reg);
            res_next.level          = lev_reg;
            res_next.uncalibrated   = uncal_reg;
            res_next.position       = pos_reg;
            res_next.position_valid = last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            wsum_reg      <= '0;
            lsum_reg      <= '0;
            for (int i = 0; i < SENSORS; i++)
            begin
                min_reg[i]  <= '1;
                max_reg[i]  <= '0;
                seen_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            wsum_reg      <= wsum_next;
            lsum_reg      <= lsum_next;
            if (calib_wr)
            begin
                if (smp_in < min_reg[addr])
                begin
                    min_reg[addr] <= smp_in;
                end
                if (smp_in > max_reg[addr])
                begin
                    max_reg[addr] <= smp_in;
                end
                seen_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        smp_reg   <= smp_next;
        last_reg  <= last_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        uncal_reg <= uncal_next;
        lev_reg   <= lev_next;
        pos_reg   <= pos_next;
        res_reg   <= res_next;
    end

    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;

    lscp_mul #(
        .A_W (DEN_W),
        .B_W (LEVEL_W),
        .P_W (NUM_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    lscp_div #(
        .N_W (NUM_W),
        .D_W (DEN_W),
        .Q_W (QUOT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );
endmodule
